FILE: src/least_loaded_eligible_select_defines.svh
// Assertion macros for the least_loaded_eligible_select checker.
// Each checker that includes this file needs clk and rst_n in scope.
`ifndef LEAST_LOADED_ELIGIBLE_SELECT_DEFINES_SVH
`define LEAST_LOADED_ELIGIBLE_SELECT_DEFINES_SVH

// Same-cycle implication.
`define LLES_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lles assertion failed (same cycle)");

// Next-cycle implication.
`define LLES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lles assertion failed (next cycle)");

`endif

FILE: src/lles_pkg.sv
// Package for least_loaded_eligible_select: sizes, constants and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package lles_pkg;

    localparam int SLOTS      = 1024;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int PTR_W      = IDX_W + 1;
    localparam int KEY_W      = 31;
    localparam int CNT_W      = 16;
    localparam int ECNT_W     = 11;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [ECNT_W-1:0] ECNT_RESET = ECNT_W'(1024);

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    localparam logic [2:0] REG_ENTRY_COUNT = 3'd0;

    typedef struct packed {
        logic addr_rst;   // zero the scan/clear address
        logic addr_inc;   // step the address
        logic clr_wr;     // write zero count at address
        logic key_wr;     // store the input key at the load pointer
        logic in_cap;     // capture the request threshold
        logic best_rst;   // forget the running best
        logic rd_en;      // read key and count at address
        logic cnt_wr;     // write back the chosen count
        logic out_load;   // load the result register
    } cmd_t;

    typedef struct packed {
        logic clr_last;   // address at last slot of the clear pass
        logic scan_last;  // address at last in-use slot
        logic n_zero;     // no slot in use
        logic out_busy;   // result register held by a stall
    } status_t;

endpackage

`default_nettype wire

FILE: src/lles_ctrl.sv
// Controller for least_loaded_eligible_select: sequences clear, load, scan,
// write-back and result hand-off. Depends on lles_pkg.
`default_nettype none

module lles_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_action,
    output logic                   in_ready,
    input  wire lles_pkg::status_t sts,
    output lles_pkg::cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr   = 1'b1;
                cmd.addr_inc = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.addr_inc = 1'b0;
                    cmd.addr_rst = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_action == lles_pkg::ACT_LOAD)
                    begin
                        cmd.key_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.in_cap   = 1'b1;
                        cmd.best_rst = 1'b1;
                        cmd.addr_rst = 1'b1;
                        state_next   = sts.n_zero ? ST_OUT : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_inc = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.cnt_wr = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/lles_dp.sv
// Datapath for least_loaded_eligible_select: key and count memories,
// scan compare, saturating write-back and result register. Uses lles_pkg.
`default_nettype none

module lles_dp
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lles_pkg::cmd_t                cmd,
    output lles_pkg::status_t                  sts,
    input  wire logic [lles_pkg::ECNT_W-1:0]   entry_count,
    input  wire logic [lles_pkg::KEY_W-1:0]    key_in,
    input  wire logic [lles_pkg::KEY_W-1:0]    thr_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_found,
    output logic [lles_pkg::IDX_W-1:0]         out_slot,
    output logic [lles_pkg::CNT_W-1:0]         out_count
);

    logic [lles_pkg::KEY_W-1:0] key_mem [lles_pkg::SLOTS];
    logic [lles_pkg::CNT_W-1:0] cnt_mem [lles_pkg::SLOTS];

    logic [lles_pkg::PTR_W-1:0]  load_ptr_reg;
    logic [lles_pkg::IDX_W-1:0]  addr_reg;
    logic [lles_pkg::IDX_W-1:0]  rd_addr_reg;
    logic                        rd_v_reg;
    logic [lles_pkg::KEY_W-1:0]  key_q_reg;
    logic [lles_pkg::CNT_W-1:0]  cnt_q_reg;
    logic [lles_pkg::KEY_W-1:0]  thr_reg;
    logic                        have_reg;
    logic [lles_pkg::IDX_W-1:0]  best_slot_reg;
    logic [lles_pkg::CNT_W-1:0]  best_cnt_reg;
    logic                        out_valid_reg;
    logic                        out_found_reg;
    logic [lles_pkg::IDX_W-1:0]  out_slot_reg;
    logic [lles_pkg::CNT_W-1:0]  out_count_reg;

    logic [lles_pkg::PTR_W-1:0]  n_eff;
    logic [lles_pkg::CNT_W-1:0]  new_cnt;
    logic                        take;

    // Register values above the table size act as the table size.
    assign n_eff = (entry_count > lles_pkg::PTR_W'(lles_pkg::SLOTS))
                 ? lles_pkg::PTR_W'(lles_pkg::SLOTS) : lles_pkg::PTR_W'(entry_count);

    assign sts.clr_last  = (addr_reg == lles_pkg::IDX_W'(lles_pkg::SLOTS - 1));
    assign sts.scan_last = ({1'b0, addr_reg} == (n_eff - lles_pkg::PTR_W'(1)));
    assign sts.n_zero    = (n_eff == '0);
    assign sts.out_busy  = out_valid_reg && !out_ready;

    assign new_cnt = (best_cnt_reg == lles_pkg::CNT_MAX) ? best_cnt_reg
                   : best_cnt_reg + lles_pkg::CNT_W'(1);

    // Strict less-than on ascending scan keeps ties at the lowest slot.
    assign take = rd_v_reg && (key_q_reg > thr_reg)
               && (!have_reg || (cnt_q_reg < best_cnt_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.key_wr && (load_ptr_reg < lles_pkg::PTR_W'(lles_pkg::SLOTS)))
        begin
            key_mem[load_ptr_reg[lles_pkg::IDX_W-1:0]] <= key_in;
        end
        if (cmd.rd_en)
        begin
            key_q_reg <= key_mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            cnt_mem[addr_reg] <= '0;
        end
        else if (cmd.cnt_wr && have_reg)
        begin
            cnt_mem[best_slot_reg] <= new_cnt;
        end
        if (cmd.rd_en)
        begin
            cnt_q_reg <= cnt_mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= addr_reg;
        if (cmd.in_cap)
        begin
            thr_reg <= thr_in;
        end
        if (take)
        begin
            best_slot_reg <= rd_addr_reg;
            best_cnt_reg  <= cnt_q_reg;
        end
        if (cmd.out_load)
        begin
            out_found_reg <= have_reg;
            out_slot_reg  <= have_reg ? best_slot_reg : '0;
            out_count_reg <= have_reg ? new_cnt : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_ptr_reg  <= '0;
            addr_reg      <= '0;
            rd_v_reg      <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.key_wr && (load_ptr_reg < lles_pkg::PTR_W'(lles_pkg::SLOTS)))
            begin
                load_ptr_reg <= load_ptr_reg + lles_pkg::PTR_W'(1);
            end
            if (cmd.addr_rst)
            begin
                addr_reg <= '0;
            end
            else if (cmd.addr_inc)
            begin
                addr_reg <= addr_reg + lles_pkg::IDX_W'(1);
            end
            rd_v_reg <= cmd.rd_en;
            if (cmd.best_rst)
            begin
                have_reg <= 1'b0;
            end
            else if (take)
            begin
                have_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_slot  = out_slot_reg;
    assign out_count = out_count_reg;

endmodule

`default_nettype wire

FILE: src/least_loaded_eligible_select.sv
// Top level of least_loaded_eligible_select: streams, APB register and the
// controller/datapath pair. Depends on lles_pkg, lles_ctrl, lles_dp.
//
//  channel | dir | handshake         | beat contents
//  --------+-----+-------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready | tdata: key_value, threshold; tuser: action
//  m_*     | out | m_tvalid/m_tready | tdata: chosen_slot, new_count; tuser: found
//  apb     | in  | psel/penable      | reg 0 at 0x0: entry_count (11 bits)
//
// A load beat stores its key at the load pointer. A request scans the n
// in-use slots one per cycle through the single read port of each memory.
// After reset a clearing pass zeroes all 1024 counts before the first beat
// is taken; APB writes are taken throughout.
// A new input beat is taken while a finished result waits on m_tready.
`default_nettype none

module least_loaded_eligible_select
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [30:0] key_value, [61:31] threshold, rest zero
    input  wire logic [0:0]  s_tuser,   // [0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [9:0] chosen_slot, [25:10] new_count, rest zero
    output logic [0:0]       m_tuser,   // [0] found
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    lles_pkg::cmd_t    cmd;
    lles_pkg::status_t sts;

    logic [lles_pkg::ECNT_W-1:0] entry_count_reg;
    logic                        out_found;
    logic [lles_pkg::IDX_W-1:0]  out_slot;
    logic [lles_pkg::CNT_W-1:0]  out_count;

    // Register file: a single word, always ready.
    assign pready = 1'b1;
    assign prdata = (paddr == lles_pkg::REG_ENTRY_COUNT)
                  ? {{(32 - lles_pkg::ECNT_W){1'b0}}, entry_count_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= lles_pkg::ECNT_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr == lles_pkg::REG_ENTRY_COUNT))
        begin
            entry_count_reg <= pwdata[lles_pkg::ECNT_W-1:0];
        end
    end

    lles_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_action (s_tuser[0]),
        .in_ready  (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lles_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .entry_count (entry_count_reg),
        .key_in      (s_tdata[30:0]),
        .thr_in      (s_tdata[61:31]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_found   (out_found),
        .out_slot    (out_slot),
        .out_count   (out_count)
    );

    assign m_tuser = out_found;
    assign m_tdata = {6'b0, out_count, out_slot};

endmodule

`default_nettype wire

FILE: src/lles_checker.sv
// Port-level checker for least_loaded_eligible_select, bound to the top level.
// Depends on least_loaded_eligible_select_defines.svh.
`default_nettype none
`include "least_loaded_eligible_select_defines.svh"

module lles_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // A miss reports slot and count as zero.
    `LLES_ASSERT_IMPL(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == 32'd0)
    // A hit always reports a count after increment, never zero.
    `LLES_ASSERT_IMPL(a_hit_count, m_tvalid && m_tuser[0], m_tdata[25:10] != 16'd0)
    // A stalled beat holds.
    `LLES_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind least_loaded_eligible_select lles_checker u_lles_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
